[src/mat_pkg.sv]
// Shared types and constants for the multicolor ant step block.
package mat_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam int COLOR_W = 6;
  localparam int SIZE_W  = 9;
  localparam int COUNT_W = 7;
  localparam int TURN_W  = 64;
  localparam int HEAD_W  = 2;

  localparam logic [SIZE_W-1:0]  WIDTH_RST = 9'd256;
  localparam logic [SIZE_W-1:0]  HEIGHT_RST = 9'd256;
  localparam logic [COUNT_W-1:0] COUNT_RST = 7'd4;

  // Headings: 0 is -x, 1 is -y, 2 is +x, 3 is +y.
  localparam logic [HEAD_W-1:0] HEAD_NEG_X = 2'd0;
  localparam logic [HEAD_W-1:0] HEAD_NEG_Y = 2'd1;
  localparam logic [HEAD_W-1:0] HEAD_POS_X = 2'd2;
  localparam logic [HEAD_W-1:0] HEAD_POS_Y = 2'd3;

  typedef enum logic [1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_HEIGHT = 2'd1,
    CFG_COLOR_COUNT = 2'd2,
    CFG_TURN_BITS   = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_ISSUE,
    ST_UPDATE
  } step_state_t;

  typedef struct packed {
    logic [SIZE_W-1:0]  grid_width;
    logic [SIZE_W-1:0]  grid_height;
    logic [COUNT_W-1:0] color_count;
    logic [TURN_W-1:0]  turn_bits;
  } cfg_t;

endpackage

[src/mat_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module mat_ram
  import mat_pkg::*;
#(
  parameter int WIDTH = COLOR_W,
  parameter int DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/mat_cfg.sv]
// Configuration registers written through the plain write port.
module mat_cfg
  import mat_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [TURN_W-1:0] cfg_wdata,
  output cfg_t              cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_width  <= WIDTH_RST;
      cfg.grid_height <= HEIGHT_RST;
      cfg.color_count <= COUNT_RST;
      cfg.turn_bits   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_GRID_WIDTH:  cfg.grid_width  <= cfg_wdata[SIZE_W-1:0];
        CFG_GRID_HEIGHT: cfg.grid_height <= cfg_wdata[SIZE_W-1:0];
        CFG_COLOR_COUNT: cfg.color_count <= cfg_wdata[COUNT_W-1:0];
        CFG_TURN_BITS:   cfg.turn_bits   <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

[src/mat_core.sv]
// Step sequencer: moves the ant, reads and rewrites the cell, sweeps clears.
module mat_core
  import mat_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [23:0]        m_tdata,
  output logic               ram_we,
  output logic [AW-1:0]      ram_waddr,
  output logic [COLOR_W-1:0] ram_wdata,
  output logic               ram_re,
  output logic [AW-1:0]      ram_raddr,
  input  logic [COLOR_W-1:0] ram_rdata
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int WCW = $clog2(MAX_WIDTH + 1);
  localparam int HCW = $clog2(MAX_HEIGHT + 1);
  localparam int PW = YW + WCW;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int RST_W = (int'(WIDTH_RST) > MAX_WIDTH) ? MAX_WIDTH : int'(WIDTH_RST);
  localparam int RST_H = (int'(HEIGHT_RST) > MAX_HEIGHT) ? MAX_HEIGHT : int'(HEIGHT_RST);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  step_state_t state, state_next;

  logic              hold_valid;
  logic              hold_clear;
  logic [XW-1:0]     ant_x;
  logic [YW-1:0]     ant_y;
  logic [HEAD_W-1:0] heading;
  logic [AW-1:0]     step_addr;
  logic [AW-1:0]     clr_addr;

  logic              consume, issue_go, clear_go, upd_go;
  logic [WCW-1:0]    eff_w, nx_ext;
  logic [HCW-1:0]    eff_h, ny_ext;
  logic [XW-1:0]     nx;
  logic [YW-1:0]     ny;
  logic [PW-1:0]     row_base;
  logic [AW-1:0]     move_addr;
  logic [HEAD_W-1:0] heading_next;
  logic [COUNT_W-1:0] color_inc;
  logic [COLOR_W-1:0] color_next;

  assign consume  = (state == ST_ISSUE) && hold_valid;
  assign issue_go = consume && !hold_clear;
  assign clear_go = consume && hold_clear;
  assign upd_go   = (state == ST_UPDATE) && (!m_tvalid || m_tready);
  // The input stage refills in the same cycle its beat moves on.
  assign s_tready = !hold_valid || consume;

  // Effective grid size: zero acts as one, anything above the maximum clamps.
  always_comb begin
    if (cfg.grid_width == '0) begin
      eff_w = WCW'(1);
    end else if (32'(cfg.grid_width) > 32'(MAX_WIDTH)) begin
      eff_w = WCW'(MAX_WIDTH);
    end else begin
      eff_w = WCW'(cfg.grid_width);
    end
    if (cfg.grid_height == '0) begin
      eff_h = HCW'(1);
    end else if (32'(cfg.grid_height) > 32'(MAX_HEIGHT)) begin
      eff_h = HCW'(MAX_HEIGHT);
    end else begin
      eff_h = HCW'(cfg.grid_height);
    end
  end

  // Move one cell with toroidal wrap; a coordinate left outside a shrunken
  // grid falls back to zero.
  always_comb begin
    nx_ext = WCW'(ant_x);
    ny_ext = HCW'(ant_y);
    unique case (heading)
      HEAD_NEG_X: begin
        if (ant_x == '0) begin
          nx_ext = eff_w - WCW'(1);
        end else begin
          nx_ext = WCW'(ant_x) - WCW'(1);
          if (nx_ext >= eff_w) nx_ext = '0;
        end
        if (ny_ext >= eff_h) ny_ext = '0;
      end
      HEAD_NEG_Y: begin
        if (ant_y == '0) begin
          ny_ext = eff_h - HCW'(1);
        end else begin
          ny_ext = HCW'(ant_y) - HCW'(1);
          if (ny_ext >= eff_h) ny_ext = '0;
        end
        if (nx_ext >= eff_w) nx_ext = '0;
      end
      HEAD_POS_X: begin
        nx_ext = WCW'(ant_x) + WCW'(1);
        if (nx_ext >= eff_w) nx_ext = '0;
        if (ny_ext >= eff_h) ny_ext = '0;
      end
      HEAD_POS_Y: begin
        ny_ext = HCW'(ant_y) + HCW'(1);
        if (ny_ext >= eff_h) ny_ext = '0;
        if (nx_ext >= eff_w) nx_ext = '0;
      end
      default: ;
    endcase
    nx = XW'(nx_ext);
    ny = YW'(ny_ext);
    row_base  = PW'(ny) * PW'(eff_w);
    move_addr = AW'(row_base) + AW'(nx);
  end

  // Turn and recolor from the color read back.
  always_comb begin
    if (cfg.turn_bits[ram_rdata]) begin
      heading_next = heading + HEAD_W'(1);
    end else begin
      heading_next = heading - HEAD_W'(1);
    end
    color_inc = COUNT_W'(ram_rdata) + COUNT_W'(1);
    if (color_inc == cfg.color_count - COUNT_W'(1)) begin
      color_next = COLOR_W'(1);
    end else begin
      color_next = color_inc[COLOR_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_addr == LAST_ADDR) state_next = ST_ISSUE;
      ST_ISSUE: begin
        if (issue_go) begin
          state_next = ST_UPDATE;
        end else if (clear_go) begin
          state_next = ST_CLEAR;
        end
      end
      ST_UPDATE: if (upd_go) state_next = ST_ISSUE;
      default:   state_next = ST_ISSUE;
    endcase
  end

  always_comb begin
    ram_re    = issue_go;
    ram_raddr = move_addr;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      default: begin
        ram_we    = upd_go;
        ram_waddr = step_addr;
        ram_wdata = color_next;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      hold_valid <= 1'b0;
      clr_addr   <= '0;
      ant_x      <= XW'(RST_W / 2);
      ant_y      <= YW'(RST_H / 2);
      heading    <= HEAD_NEG_X;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (s_tvalid && s_tready) begin
        hold_valid <= 1'b1;
      end else if (consume) begin
        hold_valid <= 1'b0;
      end
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end else begin
        clr_addr <= '0;
      end
      if (issue_go) begin
        ant_x <= nx;
        ant_y <= ny;
      end
      if (upd_go) begin
        heading  <= heading_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      hold_clear <= s_tdata[0];
    end
    if (issue_go) begin
      step_addr <= move_addr;
    end
    if (upd_go) begin
      m_tdata <= {heading_next, color_next, 8'(ant_y), 8'(ant_x)};
    end
  end

endmodule

[src/multicolor_ant_step.sv]
// Top level of the multicolor ant step block: config, sequencer and cell RAM.
//
//   port group   direction  beat contents
//   cfg_*        in         register write: index 0 width, 1 height, 2 colors, 3 turn bits
//   s_*          in         one item: clear_grid in bit 0
//   m_*          out        one result per step: cell_x, cell_y, new_color, new_heading
//
// In a step the cell address is computed and read in ST_ISSUE, and the turn
// and the write-back happen in ST_UPDATE, when the read data returns.
// The input stage accepts the next beat while a step is in flight.
// After reset, and after each clear item, a sweep zeroes the cell RAM one entry
// per cycle over all MAX_WIDTH * MAX_HEIGHT entries, and no step starts during it.
// A result held on m_tdata stalls the ST_UPDATE write-back of the next step.
module multicolor_ant_step
  import mat_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [TURN_W-1:0] cfg_wdata,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [0] clear_grid
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [23:0]       m_tdata    // [7:0] cell_x, [15:8] cell_y,
                                       // [21:16] new_color, [23:22] new_heading
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = $clog2(DEPTH);

  cfg_t               cfg;
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [COLOR_W-1:0] ram_wdata, ram_rdata;

  mat_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .cfg      (cfg)
  );

  mat_core #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_re   (ram_re),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata)
  );

  mat_ram #(
    .WIDTH(COLOR_W),
    .DEPTH(DEPTH)
  ) u_cells (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

endmodule

[sim/multicolor_ant_step_tb.sv]
// Testbench for multicolor_ant_step: ant walks checked against a cycle-free turmite predictor.
module multicolor_ant_step_tb;
  import mat_pkg::*;

  localparam int IDLE_PCT    = 38;
  localparam int GRID_CELLS  = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
  localparam int SWEEP_WAIT  = GRID_CELLS + 64;
  // Reset sweep plus a handful of clear sweeps and their settle waits, about
  // 1700 steps under random stalls, then taken well over twice.
  localparam int CYCLE_LIMIT = 2_000_000;

  // Packed from the top bit down, so cell_x lands in the lowest byte of m_tdata.
  typedef struct packed {
    logic [HEAD_W-1:0]  new_heading;
    logic [COLOR_W-1:0] new_color;
    logic [7:0]         cell_y;
    logic [7:0]         cell_x;
  } cell_report_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = CFG_GRID_WIDTH;
  logic [TURN_W-1:0] cfg_wdata = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata = '0;   // [0] clear_grid
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [23:0]       m_tdata;        // [7:0] cell_x, [15:8] cell_y,
                                     // [21:16] new_color, [23:22] new_heading

  // Predictor state: register copies, ant and a full cell store.
  logic [SIZE_W-1:0]  grid_w_q = WIDTH_RST;
  logic [SIZE_W-1:0]  grid_h_q = HEIGHT_RST;
  logic [COUNT_W-1:0] color_count_q = COUNT_RST;
  logic [TURN_W-1:0]  turn_q = '0;
  int                 ant_x = DEF_MAX_WIDTH / 2;
  int                 ant_y = DEF_MAX_HEIGHT / 2;
  logic [HEAD_W-1:0]  heading_q = HEAD_NEG_X;
  logic [COLOR_W-1:0] cell_colors [GRID_CELLS];

  cell_report_t expected_cells[$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  logic         clear_tail = 1'b0;
  logic         calm = 1'b0;

  multicolor_ant_step dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int eff_size(input logic [SIZE_W-1:0] v, input int max_size);
    if (v == 0) return 1;
    if (int'(v) > max_size) return max_size;
    return int'(v);
  endfunction

  // One accepted beat: a clear wipes the store, a step moves, turns and paints.
  task automatic ant_step_model(input logic clr);
    int                 w, h, x, y, addr;
    logic [COLOR_W-1:0] old_c;
    logic [COUNT_W-1:0] inc, wrap_at;
    cell_report_t       rep;
    if (clr) begin
      foreach (cell_colors[i]) cell_colors[i] = '0;
      clear_tail = 1'b1;
      return;
    end
    clear_tail = 1'b0;
    w = eff_size(grid_w_q, DEF_MAX_WIDTH);
    h = eff_size(grid_h_q, DEF_MAX_HEIGHT);
    x = ant_x;
    y = ant_y;
    case (heading_q)
      HEAD_NEG_X: x = (x == 0) ? w - 1 : x - 1;
      HEAD_NEG_Y: y = (y == 0) ? h - 1 : y - 1;
      HEAD_POS_X: x = x + 1;
      default:    y = y + 1;
    endcase
    // An ant left outside a shrunken grid lands on 0 of that axis.
    if (x >= w) x = 0;
    if (y >= h) y = 0;
    ant_x = x;
    ant_y = y;
    addr = x + y * w;
    old_c = cell_colors[addr];
    heading_q = turn_q[old_c] ? heading_q + 2'd1 : heading_q - 2'd1;
    inc = {1'b0, old_c} + 7'd1;
    wrap_at = color_count_q - 7'd1;
    rep.new_color = (inc == wrap_at) ? 6'd1 : inc[COLOR_W-1:0];
    cell_colors[addr] = rep.new_color;
    rep.cell_x = x[7:0];
    rep.cell_y = y[7:0];
    rep.new_heading = heading_q;
    expected_cells.push_back(rep);
  endtask

  always @(posedge clk) begin
    cell_report_t want;
    cell_report_t got;
    m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (expected_cells.size() == 0) begin
        $error("unexpected result beat: x %0d y %0d", got.cell_x, got.cell_y);
        mismatch_count++;
      end else begin
        want = expected_cells.pop_front();
        if (got.cell_x != want.cell_x) begin
          $error("cell_x expected %0d got %0d", want.cell_x, got.cell_x);
          mismatch_count++;
        end
        if (got.cell_y != want.cell_y) begin
          $error("cell_y expected %0d got %0d", want.cell_y, got.cell_y);
          mismatch_count++;
        end
        if (got.new_color != want.new_color) begin
          $error("new_color expected %0d got %0d", want.new_color, got.new_color);
          mismatch_count++;
        end
        if (got.new_heading != want.new_heading) begin
          $error("new_heading expected %0d got %0d", want.new_heading, got.new_heading);
          mismatch_count++;
        end
      end
    end
  end

  // Valid is left high on return so back-to-back beats need no extra step.
  task automatic send_item(input logic clr);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, clr};
    do @(posedge clk); while (!s_tready);
    ant_step_model(clr);
  endtask

  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_cells.size() != 0);
  endtask

  // A trailing clear gives no result, so its sweep is waited out explicitly.
  task automatic settle_block();
    wait_all_results();
    if (clear_tail) begin
      repeat (SWEEP_WAIT) @(posedge clk);
      clear_tail = 1'b0;
    end
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [TURN_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                            input logic [COUNT_W-1:0] cc, input logic [TURN_W-1:0] turns);
    settle_block();
    write_reg(CFG_GRID_WIDTH, TURN_W'(w));
    write_reg(CFG_GRID_HEIGHT, TURN_W'(h));
    write_reg(CFG_COLOR_COUNT, TURN_W'(cc));
    write_reg(CFG_TURN_BITS, turns);
    cfg_we <= 1'b0;
    grid_w_q = w;
    grid_h_q = h;
    color_count_q = cc;
    turn_q = turns;
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(9))
      0:       return 9'd0;
      1:       return 9'd1;
      2:       return 9'd256;
      3:       return SIZE_W'($urandom_range(257, 511));
      4:       return SIZE_W'($urandom_range(1, 256));
      default: return SIZE_W'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic logic [COUNT_W-1:0] pick_count();
    case ($urandom_range(7))
      0:       return 7'd0;
      1:       return 7'd4;
      2:       return 7'd64;
      3:       return COUNT_W'($urandom_range(65, 127));
      default: return COUNT_W'($urandom_range(4, 64));
    endcase
  endfunction

  function automatic logic [TURN_W-1:0] pick_turns();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Reset state: ant at the centre facing -x, default rule turns left always.
  task automatic check_reset_walk();
    repeat (4) send_item(1'b0);
  endtask

  // Shrunken grids strand the ant outside; zero and oversize dimensions clamp.
  task automatic check_grid_edges();
    set_config(9'd3, 9'd2, 7'd4, '1);
    repeat (4) send_item(1'b0);
    set_config(9'd0, 9'd0, 7'd5, 64'hAAAA_AAAA_AAAA_AAAA);
    repeat (3) send_item(1'b0);
    set_config(9'd511, 9'd300, 7'd64, 64'h5555_5555_5555_5555);
    repeat (3) send_item(1'b0);
  endtask

  // Clears in the middle of a walk, then a reshape that reinterprets the store.
  task automatic check_clear_and_reshape();
    set_config(9'd4, 9'd4, 7'd6, 64'h0F0F_0F0F_0F0F_0F0F);
    repeat (3) send_item(1'b0);
    wait_all_results();
    repeat (2) send_item(1'b0);
    send_item(1'b1);
    send_item(1'b1);
    repeat (2) send_item(1'b0);
    set_config(9'd2, 9'd8, 7'd6, 64'h0F0F_0F0F_0F0F_0F0F);
    repeat (4) send_item(1'b0);
  endtask

  // A single cell revisited: a count of 0 never matches and climbs through 63 to 0; 64 wraps from 62 to 1.
  task automatic check_color_wrap();
    set_config(9'd1, 9'd1, 7'd0, pick_turns());
    repeat (70) send_item(1'b0);
    set_config(9'd1, 9'd1, 7'd64, pick_turns());
    repeat (70) send_item(1'b0);
  endtask

  task automatic check_random_walks();
    int n_items;
    int clear_at;
    for (int ph = 0; ph < 15; ph++) begin
      set_config(pick_size(), pick_size(), pick_count(), pick_turns());
      calm <= (ph == 6 || ph == 7);
      n_items = $urandom_range(80, 120);
      clear_at = (ph % 4 == 3) ? $urandom_range(0, n_items - 1) : -1;
      for (int i = 0; i < n_items; i++) begin
        if ($urandom_range(49) == 0) wait_all_results();
        send_item(i == clear_at);
      end
    end
    settle_block();
    calm <= 1'b0;
  endtask

  initial begin
    // The block sweeps its cells to zero after reset; the predictor starts the same way.
    foreach (cell_colors[i]) cell_colors[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    check_reset_walk();
    check_grid_edges();
    check_clear_and_reshape();
    check_color_wrap();
    check_random_walks();
    settle_block();
    repeat (32) @(posedge clk);
    if (mismatch_count == 0 && expected_cells.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
src/mat_pkg.sv
src/mat_ram.sv
src/mat_cfg.sv
src/mat_core.sv
src/multicolor_ant_step.sv
sim/multicolor_ant_step_tb.sv
